@@ hw/rtl/mqttfh_pkg.sv @@
// ----------------------------------------------------------------------------
// mqttfh_pkg
// Shared types and constants for the MQTT fixed header deframer.
// ----------------------------------------------------------------------------
package mqttfh_pkg;

  // deframer phase
  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLen1 = 2'd1,
    PhLen2 = 2'd2,
    PhBody = 2'd3
  } phase_e;

  // per-byte classification
  typedef enum logic [1:0] {
    StatusDiscard = 2'd0,
    StatusPacket  = 2'd1,
    StatusReject  = 2'd2
  } status_e;

  // accepted header bytes
  localparam logic [7:0] TypeMask     = 8'hf0;
  localparam logic [7:0] TypePublish  = 8'h30;
  localparam logic [7:0] TypeConnack  = 8'h20;
  localparam logic [7:0] TypePuback   = 8'h40;
  localparam logic [7:0] TypeSuback   = 8'h90;
  localparam logic [7:0] TypePingresp = 8'hd0;

  // remaining length encoding
  localparam logic [7:0] LenValueMask = 8'h7f;
  localparam logic [7:0] LenContBit   = 8'h80;

  // fixed header sizes for one and two length bytes
  localparam logic [1:0] HdrLenShort = 2'd2;
  localparam logic [1:0] HdrLenLong  = 2'd3;

  localparam logic [7:0] MaxPacketLenReset = 8'd128;

  typedef struct packed {
    phase_e     phase;
    logic [6:0] len_low;
    logic [7:0] bytes_left;
    logic [7:0] total_len;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       first;
    logic       last;
    logic [7:0] total;
  } result_t;

endpackage

@@ hw/rtl/mqtt_fixed_header_deframer.sv @@
// The result is registered and appears in the cycle after the byte transfer while
// the output is not stalled. One byte per cycle while in_stall_o is low; the phase
// update is a combinational path from the state registers through the decoder
// back into them. A skid register behind the result register takes one more
// byte while the output stalls. Reset (async, active low) returns to hunting,
// empties both output slots and sets max_packet_len to 128.
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer
// Hunts for MQTT fixed headers, decodes the remaining length and tags each
// byte of a packet with first/last markers and the total length.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer
  import mqttfh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // byte input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] status_o,
  output logic       packet_first_o,
  output logic       packet_last_o,
  output logic [7:0] packet_total_o
);

  logic [7:0] max_len_q;
  state_t     state_q, state_d;
  result_t    result_d;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxPacketLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  mqttfh_decoder u_decoder (
    .state_i   (state_q),
    .rx_byte_i (rx_byte_i),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  // deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhHunt, len_low: 7'd0, bytes_left: 8'd0, total_len: 8'd0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output slot and skid slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = out_q.data;
  assign status_o       = out_q.status;
  assign packet_first_o = out_q.first;
  assign packet_last_o  = out_q.last;
  assign packet_total_o = out_q.total;

  // skid slot only fills behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  // a body phase always has bytes to go
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PhBody) |-> (state_q.bytes_left != 8'd0))
    else $error("body phase with no bytes left");

  // last marker only on packet bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.status == StatusPacket))
    else $error("last marker on non-packet byte");

  // header byte carries no length yet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.first) |-> (out_q.total == 8'd0 && !out_q.last))
    else $error("header byte with length or last marker");

endmodule

@@ hw/rtl/mqttfh_decoder.sv @@
// ----------------------------------------------------------------------------
// mqttfh_decoder
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module mqttfh_decoder
  import mqttfh_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] max_len_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic       is_header;
  logic [1:0] hdr_len;
  logic [7:0] remaining;
  logic [8:0] len_sum;
  logic       too_long;
  logic [7:0] left_dec;

  // header type match
  assign is_header = ((rx_byte_i & TypeMask) == TypePublish) ||
                     (rx_byte_i == TypeConnack) || (rx_byte_i == TypePuback) ||
                     (rx_byte_i == TypeSuback) || (rx_byte_i == TypePingresp);

  // decoded length for the final length byte
  always_comb begin
    if (state_i.phase == PhLen2) begin
      hdr_len   = HdrLenLong;
      remaining = {rx_byte_i[0], state_i.len_low};
    end else begin
      hdr_len   = HdrLenShort;
      remaining = {1'b0, rx_byte_i[6:0]};
    end
  end

  assign len_sum  = {1'b0, remaining} + {7'd0, hdr_len};
  assign too_long = len_sum > {1'b0, max_len_i};
  assign left_dec = state_i.bytes_left - 8'd1;

  // phase update and byte classification
  always_comb begin
    state_o         = state_i;
    result_o.data   = rx_byte_i;
    result_o.status = StatusDiscard;
    result_o.first  = 1'b0;
    result_o.last   = 1'b0;
    result_o.total  = 8'd0;

    unique case (state_i.phase) inside
      PhHunt: begin
        if (is_header) begin
          result_o.status    = StatusPacket;
          result_o.first     = 1'b1;
          state_o.total_len  = 8'd0;
          state_o.bytes_left = 8'd0;
          state_o.phase      = PhLen1;
        end
      end
      PhLen1, PhLen2: begin
        if ((state_i.phase == PhLen1) && ((rx_byte_i & LenContBit) != 8'd0)) begin
          // two-byte length, keep low bits
          state_o.len_low = 7'(rx_byte_i & LenValueMask);
          result_o.status = StatusPacket;
          state_o.phase   = PhLen2;
        end else if (((state_i.phase == PhLen2) && (rx_byte_i[7:1] != 7'd0))
                     || too_long) begin
          // bad second length byte or packet too large
          result_o.status    = StatusReject;
          state_o.phase      = PhHunt;
          state_o.bytes_left = 8'd0;
          state_o.total_len  = 8'd0;
        end else begin
          state_o.total_len = len_sum[7:0];
          result_o.total    = len_sum[7:0];
          result_o.status   = StatusPacket;
          if (remaining == 8'd0) begin
            result_o.last      = 1'b1;
            state_o.bytes_left = 8'd0;
            state_o.phase      = PhHunt;
          end else begin
            state_o.bytes_left = remaining;
            state_o.phase      = PhBody;
          end
        end
      end
      PhBody: begin
        result_o.status    = StatusPacket;
        result_o.total     = state_i.total_len;
        state_o.bytes_left = left_dec;
        if (left_dec == 8'd0) begin
          result_o.last = 1'b1;
          state_o.phase = PhHunt;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

@@ test/tb_mqtt_fixed_header_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mqtt_fixed_header_deframer
// Self-checking bench for the fixed header deframer. A directed table walks
// every header type, both length forms and each rejection path. Random
// packet streams then follow under several max packet lengths and several
// valid/stall patterns. Every result is checked field by field against a
// hand-written expectation or a cycle-free model of the deframer.
// ----------------------------------------------------------------------------
module tb_mqtt_fixed_header_deframer;
  import mqttfh_pkg::*;

  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 168;
  localparam int WatchdogLimit = 2000;

  // one stimulus byte, with an optional hand-written expectation
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    exp;
  } stim_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i   = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] byte_out_o;
  logic [1:0] status_o;
  logic       packet_first_o;
  logic       packet_last_o;
  logic [7:0] packet_total_o;

  mqtt_fixed_header_deframer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_out_o     (byte_out_o),
    .status_o       (status_o),
    .packet_first_o (packet_first_o),
    .packet_last_o  (packet_last_o),
    .packet_total_o (packet_total_o)
  );

  // model state of the deframer
  phase_e     mdl_phase    = PhHunt;
  logic [6:0] mdl_len_low  = 7'd0;
  logic [7:0] mdl_left     = 8'd0;
  logic [7:0] mdl_total    = 8'd0;
  logic [7:0] mdl_max_len  = MaxPacketLenReset;

  stim_t   rx_stim_q[$];
  result_t expected_results_q[$];
  bit      in_pending     = 1'b0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      cur_max        = int'(MaxPacketLenReset);
  int      errors         = 0;
  int      idle_cycles    = 0;

  // directed table, checked by hand where the answer is obvious
  stim_t dir_table [23] = '{
    '{8'h00, 1'b1, '{8'h00, StatusDiscard, 1'b0, 1'b0, 8'd0}},
    '{8'hff, 1'b1, '{8'hff, StatusDiscard, 1'b0, 1'b0, 8'd0}},
    '{8'h31, 1'b1, '{8'h31, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h00, 1'b1, '{8'h00, StatusPacket,  1'b0, 1'b1, 8'd2}},
    '{8'h20, 1'b1, '{8'h20, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h02, 1'b1, '{8'h02, StatusPacket,  1'b0, 1'b0, 8'd4}},
    '{8'haa, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h40, 1'b1, '{8'h40, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h7f, 1'b1, '{8'h7f, StatusReject,  1'b0, 1'b0, 8'd0}},
    '{8'h90, 1'b1, '{8'h90, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h80, 1'b0, '0},
    '{8'h02, 1'b1, '{8'h02, StatusReject,  1'b0, 1'b0, 8'd0}},
    '{8'hd0, 1'b1, '{8'hd0, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'hff, 1'b0, '0},
    '{8'h80, 1'b1, '{8'h80, StatusReject,  1'b0, 1'b0, 8'd0}},
    '{8'h3f, 1'b1, '{8'h3f, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, StatusPacket,  1'b0, 1'b1, 8'd3}},
    '{8'h21, 1'b1, '{8'h21, StatusDiscard, 1'b0, 1'b0, 8'd0}},
    '{8'h30, 1'b1, '{8'h30, StatusPacket,  1'b1, 1'b0, 8'd0}},
    '{8'h81, 1'b0, '0},
    '{8'h01, 1'b1, '{8'h01, StatusReject,  1'b0, 1'b0, 8'd0}}
  };

  // max packet length per random phase, -1 picks a random legal value
  int cfg_plan [NumPhases] = '{255, 2, 0, -1, 1, 3, -1, 128};

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // model of one byte through the deframer, updates the model state
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    bit      check_len;
    int      hdr_len;
    int      rem;
    r         = '0;
    r.data    = b;
    r.status  = StatusDiscard;
    check_len = 1'b0;
    hdr_len   = 0;
    rem       = 0;
    case (mdl_phase)
      PhHunt: begin
        if ((b & TypeMask) == TypePublish || b == TypeConnack || b == TypePuback ||
            b == TypeSuback || b == TypePingresp) begin
          r.status  = StatusPacket;
          r.first   = 1'b1;
          mdl_total = 8'd0;
          mdl_left  = 8'd0;
          mdl_phase = PhLen1;
        end
      end
      PhLen1: begin
        if ((b & LenContBit) != 8'd0) begin
          mdl_len_low = b[6:0];
          r.status    = StatusPacket;
          mdl_phase   = PhLen2;
        end else begin
          check_len = 1'b1;
          hdr_len   = int'(HdrLenShort);
          rem       = int'(b & LenValueMask);
        end
      end
      PhLen2: begin
        if (b[7] || b > 8'd1) begin
          r.status  = StatusReject;
          mdl_phase = PhHunt;
          mdl_left  = 8'd0;
          mdl_total = 8'd0;
        end else begin
          check_len = 1'b1;
          hdr_len   = int'(HdrLenLong);
          rem       = int'(mdl_len_low) + (int'(b[0]) << 7);
        end
      end
      default: begin
        r.status = StatusPacket;
        r.total  = mdl_total;
        mdl_left = mdl_left - 8'd1;
        if (mdl_left == 8'd0) begin
          r.last    = 1'b1;
          mdl_phase = PhHunt;
        end
      end
    endcase
    // length decided: accept against the max packet length or reject
    if (check_len) begin
      if (hdr_len + rem > int'(mdl_max_len)) begin
        r.status  = StatusReject;
        mdl_phase = PhHunt;
        mdl_left  = 8'd0;
        mdl_total = 8'd0;
      end else begin
        mdl_total = 8'(hdr_len + rem);
        r.total   = mdl_total;
        r.status  = StatusPacket;
        if (rem == 0) begin
          r.last    = 1'b1;
          mdl_left  = 8'd0;
          mdl_phase = PhHunt;
        end else begin
          mdl_left  = 8'(rem);
          mdl_phase = PhBody;
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    stim_t s;
    s    = '0;
    s.rx = b;
    rx_stim_q.push_back(s);
  endfunction

  // one random packet: mostly well formed, some noise and broken headers
  task automatic queue_packet();
    int         kind;
    int         rem;
    int         hdr_len;
    int         lim;
    logic [7:0] hdr;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 4))
      0:       hdr = TypeConnack;
      1:       hdr = TypePuback;
      2:       hdr = TypeSuback;
      3:       hdr = TypePingresp;
      default: hdr = TypePublish | 8'($urandom_range(0, 15));
    endcase
    queue_byte(hdr);
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // single length byte, kept within the max where possible
      rem = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 10);
      lim = (cur_max - 2 > 127) ? 127 : cur_max - 2;
      if (lim >= 0 && rem > lim) rem = $urandom_range(0, lim);
      queue_byte(8'(rem));
      hdr_len = 2;
    end else if (kind < 75) begin
      // two length bytes
      rem = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      queue_byte(8'h80 | 8'(rem & 8'h7f));
      queue_byte(8'(rem >> 7));
      hdr_len = 3;
    end else if (kind < 85) begin
      // single length byte aimed just past the max
      lim = (cur_max < 1) ? 0 : cur_max - 1;
      rem = (lim <= 127) ? $urandom_range(lim, 127) : $urandom_range(0, 10);
      queue_byte(8'(rem));
      hdr_len = 2;
    end else if (kind < 93) begin
      // illegal second length byte
      queue_byte(8'h80 | 8'($urandom_range(0, 127)));
      if ($urandom_range(0, 1) == 0) queue_byte(8'h80 | 8'($urandom_range(0, 127)));
      else queue_byte(8'($urandom_range(2, 127)));
      return;
    end else begin
      // header followed by loose bytes
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (hdr_len + rem <= cur_max) begin
      repeat (rem) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (rx_stim_q.size() != 0 || in_pending || expected_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drive byte and stall inputs on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_pending) begin
        if (rx_stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stim_q[0].rx;
          in_pending = 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // sample transfers on the rising edge
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      // result transfer, checked against the oldest expectation
      if (out_valid_o && !out_stall_i) begin
        moved        = 1'b1;
        got.data     = byte_out_o;
        got.status   = status_e'(status_o);
        got.first    = packet_first_o;
        got.last     = packet_last_o;
        got.total    = packet_total_o;
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h status %0d", $time, got.data,
                   got.status);
          errors++;
        end else begin
          want = expected_results_q.pop_front();
          if (got.data !== want.data) begin
            $display("%0t: byte_out expected %02h got %02h", $time, want.data, got.data);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.first !== want.first) begin
            $display("%0t: packet_first expected %0b got %0b", $time, want.first, got.first);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: packet_last expected %0b got %0b", $time, want.last, got.last);
            errors++;
          end
          if (got.total !== want.total) begin
            $display("%0t: packet_total expected %0d got %0d", $time, want.total, got.total);
            errors++;
          end
        end
      end
      // config transfer
      if (cfg_valid_i && cfg_ready_o) begin
        moved       = 1'b1;
        mdl_max_len = cfg_data_i;
      end
      // byte transfer
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        want  = deframe_byte(rx_byte_i);
        if (rx_stim_q.size() != 0) begin
          if (rx_stim_q[0].typed) want = rx_stim_q[0].exp;
          void'(rx_stim_q.pop_front());
        end
        expected_results_q.push_back(want);
        in_pending = 1'b0;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int value;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset max length
    foreach (dir_table[i]) rx_stim_q.push_back(dir_table[i]);
    wait_drained();

    // random phases, idling pattern rotates with the phase
    for (int p = 0; p < NumPhases; p++) begin
      value = (cfg_plan[p] < 0) ? $urandom_range(2, 255) : cfg_plan[p];
      write_max_len(8'(value));
      cur_max = value;
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      while (rx_stim_q.size() < PhaseItems) queue_packet();
      wait_drained();
    end

    // let any stray result show up
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
